// ----- rtl/lsu_pkg.sv -----
// ----------------------------------------------------------------------------
// Latency statistics unit package
// Shared widths, register indexes, the sequencer step codes and the control
// store that the statistics sequencer runs from.
// ----------------------------------------------------------------------------
package lsu_pkg;

  // Fixed field widths.
  localparam int STAMP_W   = 48;
  localparam int BOUND_W   = 20;
  localparam int OUT_W     = 20;
  localparam int CFG_IDX_W = 2;

  // Default sizes of the statistics state.
  localparam int DEF_COUNT_BITS   = 20;
  localparam int DEF_LATENCY_BITS = 20;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // Configuration register indexes.
  localparam cfg_idx_t REG_LOWER = cfg_idx_t'(0);
  localparam cfg_idx_t REG_UPPER = cfg_idx_t'(1);

  // Register reset values.
  localparam logic [BOUND_W-1:0] LOWER_RESET = BOUND_W'(0);
  localparam logic [BOUND_W-1:0] UPPER_RESET = BOUND_W'(1000000);

  // Input opcodes.
  localparam logic OPC_SAMPLE = 1'b0;
  localparam logic OPC_REPORT = 1'b1;

  // Sequencer step addresses.
  typedef logic [3:0] step_t;

  localparam step_t ST_FETCH    = step_t'(0);
  localparam step_t ST_DISPATCH = step_t'(1);
  localparam step_t ST_RCHECK   = step_t'(2);
  localparam step_t ST_DIV_SUM  = step_t'(3);
  localparam step_t ST_MEAN     = step_t'(4);
  localparam step_t ST_DIV_SQ   = step_t'(5);
  localparam step_t ST_SQUARE   = step_t'(6);
  localparam step_t ST_VAR      = step_t'(7);
  localparam step_t ST_SQRT     = step_t'(8);
  localparam step_t ST_EMIT     = step_t'(9);
  localparam step_t ST_RETURN   = step_t'(10);

  // Datapath operation selected by a control word.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_FETCH,
    OP_ACC,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_MEAN,
    OP_SQUARE,
    OP_SQRT_INIT,
    OP_SQRT_STEP,
    OP_EMIT
  } dp_op_t;

  // Jump condition: taken goes to the target, otherwise to the next step.
  typedef enum logic [2:0] {
    C_NEXT,
    C_ALWAYS,
    C_NO_WORD,
    C_SAMPLE,
    C_EMPTY,
    C_ITER_MORE,
    C_OUT_BUSY
  } cond_t;

  typedef struct packed {
    dp_op_t op;
    cond_t  cond;
    step_t  target;
  } ucode_t;

  // Control store. Samples run FETCH and DISPATCH; a non-empty report goes on
  // through the two divisions, the square, the root and the emit step.
  function automatic ucode_t ucode_rom(step_t s);
    ucode_t w;
    unique case (s)
      ST_FETCH:    w = '{op: OP_FETCH,     cond: C_NO_WORD,   target: ST_FETCH};
      ST_DISPATCH: w = '{op: OP_ACC,       cond: C_SAMPLE,    target: ST_FETCH};
      ST_RCHECK:   w = '{op: OP_DIV_INIT,  cond: C_EMPTY,     target: ST_EMIT};
      ST_DIV_SUM:  w = '{op: OP_DIV_STEP,  cond: C_ITER_MORE, target: ST_DIV_SUM};
      ST_MEAN:     w = '{op: OP_MEAN,      cond: C_NEXT,      target: ST_FETCH};
      ST_DIV_SQ:   w = '{op: OP_DIV_STEP,  cond: C_ITER_MORE, target: ST_DIV_SQ};
      ST_SQUARE:   w = '{op: OP_SQUARE,    cond: C_NEXT,      target: ST_FETCH};
      ST_VAR:      w = '{op: OP_SQRT_INIT, cond: C_NEXT,      target: ST_FETCH};
      ST_SQRT:     w = '{op: OP_SQRT_STEP, cond: C_ITER_MORE, target: ST_SQRT};
      ST_EMIT:     w = '{op: OP_EMIT,      cond: C_OUT_BUSY,  target: ST_EMIT};
      ST_RETURN:   w = '{op: OP_NOP,       cond: C_ALWAYS,    target: ST_FETCH};
      default:     w = '{op: OP_NOP,       cond: C_ALWAYS,    target: ST_FETCH};
    endcase
    return w;
  endfunction

endpackage

// ----- rtl/lsu_in_if.sv -----
// ----------------------------------------------------------------------------
// Latency statistics input channel
// Carries one sample or report word with a valid and ready handshake.
// ----------------------------------------------------------------------------
interface lsu_in_if;
  import lsu_pkg::*;

  logic               valid;
  logic               ready;
  logic               opcode;
  logic [STAMP_W-1:0] recv_stamp_us;
  logic [STAMP_W-1:0] sent_stamp_us;

  modport source (output valid, opcode, recv_stamp_us, sent_stamp_us, input ready);
  modport sink   (input valid, opcode, recv_stamp_us, sent_stamp_us, output ready);
endinterface

// ----- rtl/lsu_out_if.sv -----
// ----------------------------------------------------------------------------
// Latency statistics result channel
// Carries one statistics report word with a valid and ready handshake.
// ----------------------------------------------------------------------------
interface lsu_out_if;
  import lsu_pkg::*;

  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] sample_count;
  logic [OUT_W-1:0] mean_us;
  logic [OUT_W-1:0] min_us;
  logic [OUT_W-1:0] max_us;
  logic [OUT_W-1:0] stddev_us;
  logic             no_samples;
  logic             saturated;

  modport source (output valid, sample_count, mean_us, min_us, max_us, stddev_us,
                  no_samples, saturated, input ready);
  modport sink   (input valid, sample_count, mean_us, min_us, max_us, stddev_us,
                  no_samples, saturated, output ready);
endinterface

// ----- rtl/lsu_cfg_if.sv -----
// ----------------------------------------------------------------------------
// Latency statistics configuration channel
// Carries one register write word: a register index and the write data.
// ----------------------------------------------------------------------------
interface lsu_cfg_if;
  import lsu_pkg::*;

  logic               valid;
  logic               ready;
  cfg_idx_t           index;
  logic [BOUND_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/latency_statistics_unit.sv -----
// ----------------------------------------------------------------------------
// Latency statistics unit
// A sample word is fetched, then accumulated with one multiply-add. A report
// word runs the shared one-bit-per-cycle divider twice, squares the mean
// and takes the two-bits-per-cycle square root before the emit step; an
// empty report jumps from the check step straight to the emit step.
// Synchronous active-low reset clears the statistics, sets the bounds to
// their reset values and returns the sequencer to the fetch step.
// ----------------------------------------------------------------------------
module latency_statistics_unit #(
  parameter int COUNT_BITS   = lsu_pkg::DEF_COUNT_BITS,
  parameter int LATENCY_BITS = lsu_pkg::DEF_LATENCY_BITS
) (
  input  logic     clk,
  input  logic     rst_n,
  lsu_in_if.sink   in_ch,
  lsu_out_if.source out_ch,
  lsu_cfg_if.sink  cfg_ch
);
  import lsu_pkg::*;

  localparam int LAT_W  = LATENCY_BITS;
  localparam int CNT_W  = COUNT_BITS;
  localparam int SUM_W  = CNT_W + LAT_W;
  localparam int SQ_W   = CNT_W + 2 * LAT_W;
  localparam int ITER_W = $clog2(SQ_W + 1);

  // Configuration registers.
  logic [BOUND_W-1:0] lower_r;
  logic [BOUND_W-1:0] upper_r;

  // Statistics state.
  logic [CNT_W-1:0]   count_r;
  logic [SUM_W-1:0]   sum_r;
  logic [SQ_W-1:0]    sumsq_r;
  logic [LAT_W-1:0]   min_r;
  logic [LAT_W-1:0]   max_r;
  logic               dropped_r;

  // Sequencer.
  step_t              step_r;
  ucode_t             uc;
  logic               cond_hit;
  logic [ITER_W-1:0]  iter_r;

  // Working registers.
  logic               is_report_r;
  logic               lat_ok_r;
  logic [LAT_W-1:0]   lat_r;
  logic [SQ_W-1:0]    dq_r;
  logic [CNT_W-1:0]   div_rem_r;
  logic [LAT_W-1:0]   mean_r;
  logic [2*LAT_W-1:0] msq_r;
  logic [2*LAT_W-1:0] m2_r;
  logic [LAT_W:0]     sq_rem_r;
  logic [LAT_W-1:0]   root_r;

  // Output register.
  logic               out_valid_r;
  logic [OUT_W-1:0]   out_count_r;
  logic [OUT_W-1:0]   out_mean_r;
  logic [OUT_W-1:0]   out_min_r;
  logic [OUT_W-1:0]   out_max_r;
  logic [OUT_W-1:0]   out_std_r;
  logic               out_empty_r;
  logic               out_sat_r;

  // Combinational datapath signals.
  logic               in_fire;
  logic               out_free;
  logic [STAMP_W:0]   diff;
  logic [STAMP_W-1:0] lat_wide;
  logic               lat_ok;
  logic [CNT_W:0]     div_sh;
  logic               div_bit;
  logic [LAT_W+2:0]   sq_cat;
  logic [LAT_W+2:0]   sq_trial;
  logic               sq_bit;
  logic [2*LAT_W-1:0] var_val;
  logic               count_empty;

  assign in_ch.ready  = (step_r == ST_FETCH);
  assign cfg_ch.ready = 1'b1;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign out_free     = !out_valid_r || out_ch.ready;
  assign count_empty  = (count_r == '0);

  // Latency of the word at the input and its acceptance window.
  assign diff     = {1'b0, in_ch.recv_stamp_us} - {1'b0, in_ch.sent_stamp_us};
  assign lat_wide = diff[STAMP_W-1:0];
  assign lat_ok   = !diff[STAMP_W] && (lat_wide != '0)
                    && ((lat_wide >> LAT_W) == '0)
                    && (lat_wide > STAMP_W'(lower_r))
                    && (lat_wide < STAMP_W'(upper_r));

  // One restoring divide step on the shared quotient register.
  assign div_sh  = {div_rem_r, dq_r[SQ_W-1]};
  assign div_bit = (div_sh >= {1'b0, count_r});

  // One digit step of the square root, two radicand bits per step.
  assign sq_cat   = {sq_rem_r, dq_r[SQ_W-1 -: 2]};
  assign sq_trial = {1'b0, root_r, 2'b01};
  assign sq_bit   = (sq_cat >= sq_trial);

  // Population variance, clamped at zero.
  assign var_val = (msq_r > m2_r) ? (msq_r - m2_r) : '0;

  // Control word fetch and jump condition.
  assign uc = ucode_rom(step_r);

  always_comb begin
    case (uc.cond)
      C_NEXT:      cond_hit = 1'b0;
      C_ALWAYS:    cond_hit = 1'b1;
      C_NO_WORD:   cond_hit = !in_fire;
      C_SAMPLE:    cond_hit = (is_report_r == OPC_SAMPLE);
      C_EMPTY:     cond_hit = count_empty;
      C_ITER_MORE: cond_hit = (iter_r != ITER_W'(1));
      C_OUT_BUSY:  cond_hit = !out_free;
      default:     cond_hit = 1'b0;
    endcase
  end

  // Step counter, configuration, statistics and output handshake.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= ST_FETCH;
      lower_r     <= LOWER_RESET;
      upper_r     <= UPPER_RESET;
      count_r     <= '0;
      sum_r       <= '0;
      sumsq_r     <= '0;
      min_r       <= '1;
      max_r       <= '0;
      dropped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      step_r <= cond_hit ? uc.target : step_r + step_t'(1);

      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.index == REG_LOWER) begin
          lower_r <= cfg_ch.data;
        end else if (cfg_ch.index == REG_UPPER) begin
          upper_r <= cfg_ch.data;
        end
      end

      // A new report fills the output register; a taken report frees it.
      if (uc.op == OP_EMIT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      // Accumulate an accepted sample, or drop it on a full count.
      if (uc.op == OP_ACC && is_report_r == OPC_SAMPLE && lat_ok_r) begin
        if (count_r == '1) begin
          dropped_r <= 1'b1;
        end else begin
          count_r <= count_r + CNT_W'(1);
          sum_r   <= sum_r + SUM_W'(lat_r);
          sumsq_r <= sumsq_r + SQ_W'(lat_r * lat_r);
          if (lat_r < min_r) begin
            min_r <= lat_r;
          end
          if (lat_r > max_r) begin
            max_r <= lat_r;
          end
        end
      end

      // Deliver the report and clear the statistics.
      if (uc.op == OP_EMIT && out_free) begin
        count_r     <= '0;
        sum_r       <= '0;
        sumsq_r     <= '0;
        min_r       <= '1;
        max_r       <= '0;
        dropped_r   <= 1'b0;
      end
    end
  end

  // Working registers of the shared divider, multiplier and root unit.
  always_ff @(posedge clk) begin
    case (uc.op)
      OP_FETCH: begin
        if (in_fire) begin
          is_report_r <= in_ch.opcode;
          lat_ok_r    <= lat_ok;
          lat_r       <= lat_wide[LAT_W-1:0];
        end
      end
      OP_DIV_INIT: begin
        dq_r      <= {sum_r, {(SQ_W - SUM_W){1'b0}}};
        div_rem_r <= '0;
        iter_r    <= ITER_W'(SUM_W);
      end
      OP_DIV_STEP: begin
        dq_r      <= {dq_r[SQ_W-2:0], div_bit};
        div_rem_r <= div_bit ? CNT_W'(div_sh - {1'b0, count_r}) : CNT_W'(div_sh);
        iter_r    <= iter_r - ITER_W'(1);
      end
      OP_MEAN: begin
        mean_r    <= dq_r[LAT_W-1:0];
        dq_r      <= sumsq_r;
        div_rem_r <= '0;
        iter_r    <= ITER_W'(SQ_W);
      end
      OP_SQUARE: begin
        msq_r <= dq_r[2*LAT_W-1:0];
        m2_r  <= mean_r * mean_r;
      end
      OP_SQRT_INIT: begin
        dq_r     <= {var_val, {CNT_W{1'b0}}};
        sq_rem_r <= '0;
        root_r   <= '0;
        iter_r   <= ITER_W'(LAT_W);
      end
      OP_SQRT_STEP: begin
        dq_r     <= {dq_r[SQ_W-3:0], 2'b00};
        sq_rem_r <= sq_bit ? (LAT_W+1)'(sq_cat - sq_trial) : (LAT_W+1)'(sq_cat);
        root_r   <= {root_r[LAT_W-2:0], sq_bit};
        iter_r   <= iter_r - ITER_W'(1);
      end
      OP_EMIT: begin
        if (out_free) begin
          if (count_empty) begin
            out_count_r <= '0;
            out_mean_r  <= '0;
            out_min_r   <= '0;
            out_max_r   <= '0;
            out_std_r   <= '0;
            out_empty_r <= 1'b1;
            out_sat_r   <= 1'b0;
          end else begin
            out_count_r <= OUT_W'(count_r);
            out_mean_r  <= OUT_W'(mean_r);
            out_min_r   <= OUT_W'(min_r);
            out_max_r   <= OUT_W'(max_r);
            out_std_r   <= OUT_W'(root_r);
            out_empty_r <= 1'b0;
            out_sat_r   <= dropped_r;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Result channel.
  assign out_ch.valid        = out_valid_r;
  assign out_ch.sample_count = out_count_r;
  assign out_ch.mean_us      = out_mean_r;
  assign out_ch.min_us       = out_min_r;
  assign out_ch.max_us       = out_max_r;
  assign out_ch.stddev_us    = out_std_r;
  assign out_ch.no_samples   = out_empty_r;
  assign out_ch.saturated    = out_sat_r;

endmodule
